@@ hdl/fwd_pkg.sv @@
// ---------------------------------------------------------------------------
// fwd_pkg
// Shared constants and types for the FIFO with delete by value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fwd_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_DEQ = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef struct packed {
    logic deq;       // shift whole row toward head
    logic del;       // delete in progress, compare against key
    logic load;      // write key into this cell
    logic occupied;  // cell index below count
  } fwd_ctl_t;

endpackage

`default_nettype wire

@@ hdl/fwd_cell.sv @@
// ---------------------------------------------------------------------------
// fwd_cell
// One storage cell of the queue: holds an entry, compares it against the
// delete key and takes its right neighbor's entry when the row closes a gap.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fwd_cell (
  input  wire logic                            clk,
  input  wire fwd_pkg::fwd_ctl_t               ctl,
  input  wire logic [fwd_pkg::VALUE_WIDTH-1:0] key,
  input  wire logic                            hit_in,
  input  wire logic [fwd_pkg::VALUE_WIDTH-1:0] right_value,
  output logic                                 hit_out,
  output logic      [fwd_pkg::VALUE_WIDTH-1:0] value
);
  import fwd_pkg::*;

  logic match;
  logic shift;

  assign match   = ctl.occupied & ctl.del & (value == key);
  assign hit_out = hit_in | match;
  assign shift   = ctl.deq | (ctl.del & hit_out);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= key;
    end else if (shift) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire

@@ hdl/fifo_with_delete_by_value.sv @@
// ---------------------------------------------------------------------------
// fifo_with_delete_by_value
// Bounded FIFO of nonzero handles with enqueue, dequeue and delete of the
// first matching entry, built as a row of cells that shift toward the head.
// ---------------------------------------------------------------------------
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while the output is not stalled; the match chain across the cell row
// and the shift into each cell complete in the accepting cycle.
// Reset: clears the occupancy count and the output valid; cell contents
// stay undefined until written and are never read past the count.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_delete_by_value (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] item_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             status,
  output logic      [31:0] out_value,
  output logic      [4:0]  occupancy
);
  import fwd_pkg::*;

  logic                   accept;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [VALUE_WIDTH-1:0] key;
  logic                   key_nz;
  logic                   full;
  logic                   empty;
  logic                   found;
  logic                   ok;
  logic                   do_deq;
  logic                   do_del;
  logic                   do_enq;
  logic [DEPTH:0]         hit;
  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign key    = item_value[VALUE_WIDTH-1:0];
  assign key_nz = (key != '0);
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign found  = hit[DEPTH];
  assign hit[0] = 1'b0;

  assign do_enq = accept & (func == OP_ENQ) & key_nz & ~full;
  assign do_deq = accept & (func == OP_DEQ) & ~empty;
  assign do_del = accept & (func == OP_DEL) & key_nz & ~empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fwd_ctl_t               ctl;
    logic [VALUE_WIDTH-1:0] right;

    assign ctl.deq      = do_deq;
    assign ctl.del      = do_del;
    assign ctl.load     = do_enq & (count == CNT_W'(i));
    assign ctl.occupied = (CNT_W'(i) < count);

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_value[i+1];
    end

    fwd_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key),
      .hit_in      (hit[i]),
      .right_value (right),
      .hit_out     (hit[i+1]),
      .value       (cell_value[i])
    );
  end

  always_comb begin
    ok         = 1'b0;
    count_next = count;
    case (func)
      OP_ENQ: begin
        ok = key_nz & ~full;
        if (ok) count_next = count + CNT_W'(1);
      end
      OP_DEQ: begin
        ok = ~empty;
        if (ok) count_next = count - CNT_W'(1);
      end
      OP_DEL: begin
        ok = key_nz & ~empty & found;
        if (ok) count_next = count - CNT_W'(1);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= ~ok;
      out_value <= do_deq ? 32'(cell_value[0]) : '0;
      occupancy <= 5'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_occ_tracks: assert property (@(posedge clk) disable iff (rst)
    accept |=> occupancy == 5'(count))
    else $error("reported occupancy differs from count");

  a_deq_nonnull: assert property (@(posedge clk) disable iff (rst)
    do_deq |=> out_value != '0 && !status)
    else $error("successful dequeue returned null");

endmodule

`default_nettype wire

@@ tb/fifo_with_delete_by_value_tb.sv @@
// ---------------------------------------------------------------------------
// fifo_with_delete_by_value_tb
// Self-checking bench for the FIFO with delete by value. A directed table
// covers empty, full, null and not-found cases. Random traffic then swings
// the occupancy between empty and full and reuses a small value pool so that
// deletes hit duplicates. Results are checked against the table or a model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_with_delete_by_value_tb;
  import fwd_pkg::*;

  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam int RAND_BEATS = 1550;

  typedef struct packed {
    logic             status;
    logic [31:0]      value;
    logic [CNT_W-1:0] occ;
  } op_result_t;

  typedef struct {
    logic [1:0]  f;
    logic [31:0] v;
    int          reps;
    bit          typed;
    op_result_t  exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [31:0] item_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [31:0] out_value;
  logic [4:0]  occupancy;

  logic [31:0] held_q[$];
  op_result_t  pending_results[$];
  bit          beat_typed;
  op_result_t  beat_exp;
  bit          quiet;
  int          stall_left;
  int          mismatches;

  // the fill row enqueues 2..16 behind the all-ones head
  dir_row_t dir_rows [16] = '{
    '{OP_DEQ,  32'h0,        1,  1'b1, '{1'b1, 32'h0, 5'd0}},
    '{OP_DEL,  32'h7,        1,  1'b1, '{1'b1, 32'h0, 5'd0}},
    '{OP_ENQ,  32'h0,        1,  1'b1, '{1'b1, 32'h0, 5'd0}},
    '{OP_RSVD, 32'hFFFFFFFF, 1,  1'b1, '{1'b1, 32'h0, 5'd0}},
    '{OP_ENQ,  32'hFFFFFFFF, 1,  1'b1, '{1'b0, 32'h0, 5'd1}},
    '{OP_DEL,  32'h0,        1,  1'b1, '{1'b1, 32'h0, 5'd1}},
    '{OP_ENQ,  32'h2,        15, 1'b0, '{1'b0, 32'h0, 5'd0}},
    '{OP_ENQ,  32'h5,        1,  1'b1, '{1'b1, 32'h0, 5'd16}},
    '{OP_DEL,  32'h9,        1,  1'b1, '{1'b0, 32'h0, 5'd15}},
    '{OP_DEL,  32'h10,       1,  1'b1, '{1'b0, 32'h0, 5'd14}},
    '{OP_DEL,  32'hFFFFFFFF, 1,  1'b1, '{1'b0, 32'h0, 5'd13}},
    '{OP_DEL,  32'h9,        1,  1'b1, '{1'b1, 32'h0, 5'd13}},
    '{OP_DEQ,  32'h0,        1,  1'b1, '{1'b0, 32'h2, 5'd12}},
    '{OP_ENQ,  32'h3,        1,  1'b0, '{1'b0, 32'h0, 5'd0}},
    '{OP_DEL,  32'h3,        1,  1'b1, '{1'b0, 32'h0, 5'd12}},
    '{OP_DEQ,  32'h0,        1,  1'b1, '{1'b0, 32'h4, 5'd11}}
  };

  fifo_with_delete_by_value i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .item_value (item_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_value  (out_value),
    .occupancy  (occupancy)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic op_result_t fifo_apply(input logic [1:0] f, input logic [31:0] v);
    op_result_t res;
    int idx;
    res = '{1'b1, 32'h0, '0};
    idx = -1;
    case (f)
      OP_ENQ: begin
        if (v != 0 && held_q.size() < DEPTH) begin
          held_q.push_back(v);
          res.status = 1'b0;
        end
      end
      OP_DEQ: begin
        if (held_q.size() > 0) begin
          res.value  = held_q.pop_front();
          res.status = 1'b0;
        end
      end
      OP_DEL: begin
        if (v != 0) begin
          foreach (held_q[i]) if (idx < 0 && held_q[i] == v) idx = i;
          if (idx >= 0) begin
            held_q.delete(idx);
            res.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.occ = CNT_W'(held_q.size());
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  // entered and left at a falling edge
  task automatic send_beat(input logic [1:0] f, input logic [31:0] v, input bit typed,
                           input op_result_t exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    func       = f;
    item_value = v;
    beat_typed = typed;
    beat_exp   = exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    op_result_t pred;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = fifo_apply(func, item_value);
        pending_results.push_back(beat_typed ? beat_exp : pred);
      end
      if (out_valid && !out_stall) begin
        got = '{status, out_value, occupancy};
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status %b, want %b", got.status, want.status));
          if (got.value !== want.value)
            report_mismatch($sformatf("out_value %h, want %h", got.value, want.value));
          if (got.occ !== want.occ)
            report_mismatch($sformatf("occupancy %0d, want %0d", got.occ, want.occ));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int r;
    int enq_w;
    int deq_w;
    logic [1:0] f;
    logic [31:0] v;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = OP_ENQ;
    item_value = 32'h0;
    beat_typed = 1'b0;
    beat_exp   = '0;
    quiet      = 1'b0;
    stall_left = 0;
    mismatches = 0;
    enq_w      = 40;
    deq_w      = 30;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_beat(dir_rows[i].f, dir_rows[i].v + k, dir_rows[i].typed, dir_rows[i].exp);
    end

    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 100 == 0) begin
        quiet = ($urandom_range(3) == 0);
        case ($urandom_range(2))
          0: begin enq_w = 60; deq_w = 17; end
          1: begin enq_w = 25; deq_w = 50; end
          default: begin enq_w = 40; deq_w = 30; end
        endcase
      end
      if (n % 250 == 125) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 3) f = OP_RSVD;
      else if (r < 3 + enq_w) f = OP_ENQ;
      else if (r < 3 + enq_w + deq_w) f = OP_DEQ;
      else f = OP_DEL;
      r = $urandom_range(99);
      if (f == OP_DEL && held_q.size() > 0 && r < 70)
        v = held_q[$urandom_range(held_q.size() - 1)];
      else if (r < 5)
        v = 32'h0;
      else if (r < 55)
        v = $urandom_range(1, 12);
      else
        v = $urandom;
      send_beat(f, v, 1'b0, '0);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
